>>> hdl/fm_phase_discriminator_decimator_defines.svh
// ----------------------------------------------------------------------------
// FM discriminator assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FM_PHASE_DISCRIMINATOR_DECIMATOR_DEFINES_SVH
`define FM_PHASE_DISCRIMINATOR_DECIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FMPD_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define FMPD_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FMPD_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg)
`define FMPD_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

>>> hdl/fmpd_pkg.sv
// ----------------------------------------------------------------------------
// fmpd_pkg
// Types, constants and the arctangent table of the FM discriminator.
// ----------------------------------------------------------------------------
`default_nettype none

package fmpd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_DECIM_DEF = 64;
    localparam int CORDIC_STEPS  = 23;
    localparam int ANG_W         = 26;
    localparam int IDX_W         = 32;
    localparam int PHASE_W       = 16;
    localparam int DECIM_W       = 7;
    localparam int COLD_W        = 20;
    localparam int CFG_DW        = 20;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [DECIM_W-1:0] DECIM_RST = 7'd1;
    localparam logic [COLD_W-1:0]  COLD_RST  = 20'd512;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_DECIM = 1'b0,
        REG_COLD  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] i_sample;
        logic signed [SAMPLE_BITS-1:0] q_sample;
        logic [IDX_W-1:0]              sample_index;
        logic                          chunk_start;
        logic                          chunk_end;
    } in_item_t;

    typedef struct packed {
        logic signed [PHASE_W-1:0] phase_value;
        logic                      invalid;
        logic [IDX_W-1:0]          out_index;
        logic                      last;
    } out_item_t;

    // One classified sample passed from the front to the back.
    typedef struct packed {
        logic [PHASE_W-1:0] angle;
        logic [IDX_W-1:0]   sample_index;
        logic               chunk_start;
        logic               chunk_end;
    } phase_item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ADD,
        F_NORM,
        F_CORDIC,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MOD,
        B_CHECK,
        B_REBASE,
        B_START,
        B_AVG,
        B_EMIT,
        B_ADD
    } back_state_t;

    // Arctangent of 2^-k, with pi equal to 2^23.
    function automatic logic [21:0] atan_entry(input logic [4:0] k);
        logic [21:0] v;
        case (k)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            5'd20:   v = 22'd3;
            5'd21:   v = 22'd1;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/fmpd_front.sv
// ----------------------------------------------------------------------------
// fmpd_front
// Accepts samples, forms the conjugate product and finds its angle with an
// iterative CORDIC, then hands the angle to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpd_front
    import fmpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             push_valid,
    input  wire logic        push_ready,
    output phase_item_t      push_data
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int CW     = ((PROD_W > 41) ? PROD_W : 41) + 4;
    localparam logic signed [CW-1:0] NORM_POS = {{(CW-41){1'b0}}, 1'b1, 40'b0};
    localparam logic signed [CW-1:0] NORM_NEG = -NORM_POS;
    localparam logic signed [ANG_W-1:0] ANG_PI = {{(ANG_W-24){1'b0}}, 1'b1, 23'b0};
    localparam logic signed [ANG_W-1:0] ROUND  = {{(ANG_W-8){1'b0}}, 8'd128};
    localparam logic [4:0] K_LAST = 5'(CORDIC_STEPS - 1);

    front_state_t state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] prev_i_reg, prev_i_next;
    logic signed [SAMPLE_BITS-1:0] prev_q_reg, prev_q_next;
    logic signed [SAMPLE_BITS-1:0] ci_reg, ci_next, cq_reg, cq_next;
    logic signed [SAMPLE_BITS-1:0] pi_reg, pi_next, pq_reg, pq_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              start_reg, start_next, end_reg, end_next;
    logic signed [PROD_W-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic signed [PROD_W-1:0] p3_reg, p3_next, p4_reg, p4_next;
    logic signed [CW-1:0]     x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic [4:0]               k_reg, k_next;
    logic [PHASE_W-1:0]       angle_reg, angle_next;

    logic signed [CW-1:0]    sx, sy;
    logic signed [ANG_W-1:0] atan_v, z_step, z_round;
    logic                    x_small, y_small;

    // Control and previous-sample state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            prev_i_reg <= '0;
            prev_q_reg <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            prev_i_reg <= prev_i_next;
            prev_q_reg <= prev_q_next;
            k_reg      <= k_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ci_reg    <= ci_next;
        cq_reg    <= cq_next;
        pi_reg    <= pi_next;
        pq_reg    <= pq_next;
        idx_reg   <= idx_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        p3_reg    <= p3_next;
        p4_reg    <= p4_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    // One CORDIC vectoring step; shifts round toward minus infinity.
    always_comb
    begin
        sx      = x_reg >>> k_reg;
        sy      = y_reg >>> k_reg;
        atan_v  = ANG_W'($signed({1'b0, atan_entry(k_reg)}));
        z_step  = (y_reg > 0) ? (z_reg + atan_v) : (z_reg - atan_v);
        z_round = z_step + ROUND;
        x_small = (x_reg < NORM_POS) && (x_reg > NORM_NEG);
        y_small = (y_reg < NORM_POS) && (y_reg > NORM_NEG);
    end

    // Sequencer: next state and datapath.
    always_comb
    begin
        state_next  = state_reg;
        prev_i_next = prev_i_reg;
        prev_q_next = prev_q_reg;
        ci_next     = ci_reg;
        cq_next     = cq_reg;
        pi_next     = pi_reg;
        pq_next     = pq_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        p3_next     = p3_reg;
        p4_next     = p4_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        k_next      = k_reg;
        angle_next  = angle_reg;
        in_ready    = 1'b0;
        push_valid  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ci_next     = in_data.i_sample;
                    cq_next     = in_data.q_sample;
                    pi_next     = prev_i_reg;
                    pq_next     = prev_q_reg;
                    prev_i_next = in_data.i_sample;
                    prev_q_next = in_data.q_sample;
                    idx_next    = in_data.sample_index;
                    start_next  = in_data.chunk_start;
                    end_next    = in_data.chunk_end;
                    state_next  = F_MUL;
                end
            end
            F_MUL:
            begin
                p1_next    = ci_reg * pi_reg;
                p2_next    = cq_reg * pq_reg;
                p3_next    = cq_reg * pi_reg;
                p4_next    = ci_reg * pq_reg;
                state_next = F_ADD;
            end
            F_ADD:
            begin
                x_next = CW'(p1_reg) + CW'(p2_reg);
                y_next = CW'(p3_reg) - CW'(p4_reg);
                z_next = '0;
                k_next = '0;
                if (start_reg || (x_next == '0 && y_next == '0))
                begin
                    angle_next = '0;
                    state_next = F_PUSH;
                end
                else
                begin
                    state_next = F_NORM;
                end
            end
            F_NORM:
            begin
                // Double until one magnitude reaches 2^40, then fold the left half-plane.
                if (x_small && y_small)
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else
                begin
                    if (x_reg < 0)
                    begin
                        x_next = -x_reg;
                        y_next = -y_reg;
                        z_next = ANG_PI;
                    end
                    state_next = F_CORDIC;
                end
            end
            F_CORDIC:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                end
                else
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                end
                z_next = z_step;
                k_next = k_reg + 5'd1;
                if (k_reg == K_LAST)
                begin
                    angle_next = z_round[PHASE_W+7:8];
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_data.angle        = angle_reg;
    assign push_data.sample_index = idx_reg;
    assign push_data.chunk_start  = start_reg;
    assign push_data.chunk_end    = end_reg;

endmodule

`default_nettype wire

>>> hdl/fmpd_fifo.sv
// ----------------------------------------------------------------------------
// fmpd_fifo
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpd_fifo
    import fmpd_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire phase_item_t  push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output phase_item_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    phase_item_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1)) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1)) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fmpd_div.sv
// ----------------------------------------------------------------------------
// fmpd_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpd_div
    import fmpd_pkg::*;
#(
    parameter int DIVISOR_W = 7
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [IDX_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [IDX_W-1:0]          quotient,
    output logic [DIVISOR_W-1:0]      remainder
);

    localparam int STEP_W = $clog2(IDX_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(IDX_W - 1);

    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next, d_reg, d_next;
    logic [DIVISOR_W:0]   trial, diff;

    // Shift in one dividend bit and try the subtraction.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[IDX_W-1]};
        diff      = trial - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[IDX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[IDX_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hdl/fmpd_back.sv
// ----------------------------------------------------------------------------
// fmpd_back
// Groups angles into aligned windows, averages each closed window with the
// serial divider and sends one result per sample of the window.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fm_phase_discriminator_decimator_defines.svh"

module fmpd_back
    import fmpd_pkg::*;
#(
    parameter int MAX_DECIM = MAX_DECIM_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [DECIM_W-1:0] decim,
    input  wire logic [COLD_W-1:0]  cold,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire phase_item_t        pop_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data
);

    localparam int CNT_W = $clog2(MAX_DECIM + 1);
    localparam int SUM_W = PHASE_W + $clog2(MAX_DECIM) + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DECIM);

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next, k_reg, k_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    after_add_reg, after_add_next;
    phase_item_t             item_reg, item_next;
    logic [CNT_W-1:0]        r_reg, r_next;
    logic [CNT_W-1:0]        wn_reg, wn_next;
    logic [IDX_W-1:0]        base_reg, base_next, wbase_reg, wbase_next;
    logic [IDX_W-1:0]        first_reg, first_next;
    logic [PHASE_W-1:0]      avg_reg, avg_next;

    logic [CNT_W-1:0]   n_dec, cnt_inc;
    logic [SUM_W-1:0]   sum_mag;
    logic [IDX_W-1:0]   avg_num, div_dividend, div_quo, cur_index;
    logic [CNT_W-1:0]   div_divisor, div_rem;
    logic               div_start, div_busy, div_done, flush_open, close_now;
    logic [PHASE_W-1:0] q16;

    fmpd_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Decimation factor held to its legal range.
    always_comb
    begin
        if (decim == '0)
        begin
            n_dec = CNT_W'(1);
        end
        else if (decim > DECIM_W'(MAX_DECIM))
        begin
            n_dec = CNT_MAX;
        end
        else
        begin
            n_dec = CNT_W'(decim);
        end
    end

    // Rounded average operands: magnitude plus half the count.
    always_comb
    begin
        sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        avg_num    = IDX_W'(sum_mag) + IDX_W'(cnt_reg >> 1);
        q16        = div_quo[PHASE_W-1:0];
        cnt_inc    = cnt_reg + CNT_W'(1);
        flush_open = (cnt_reg != '0) && (item_reg.chunk_start || base_reg != wbase_reg ||
                     cnt_reg >= n_dec);
        cur_index  = first_reg + IDX_W'(k_reg);
    end

    // Window sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        after_add_next = after_add_reg;
        item_next      = item_reg;
        r_next         = r_reg;
        wn_next        = wn_reg;
        base_next      = base_reg;
        wbase_next     = wbase_reg;
        first_next     = first_reg;
        avg_next       = avg_reg;
        pop_ready      = 1'b0;
        out_valid      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = avg_num;
        div_divisor    = cnt_reg;
        close_now      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                pop_ready    = 1'b1;
                div_dividend = pop_data.sample_index;
                div_divisor  = n_dec;
                if (pop_valid)
                begin
                    item_next  = pop_data;
                    div_start  = 1'b1;
                    state_next = B_MOD;
                end
            end
            B_MOD:
            begin
                // Remainder locates the sample inside its aligned window.
                if (div_done)
                begin
                    r_next     = div_rem;
                    base_next  = item_reg.sample_index - IDX_W'(div_rem);
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if ((cnt_reg != '0) && (wn_reg != n_dec))
                begin
                    // The decimation changed under an open window: align its start again.
                    div_dividend = first_reg;
                    div_divisor  = n_dec;
                    div_start    = 1'b1;
                    state_next   = B_REBASE;
                end
                else if (flush_open)
                begin
                    after_add_next = 1'b1;
                    state_next     = B_START;
                end
                else
                begin
                    state_next = B_ADD;
                end
            end
            B_REBASE:
            begin
                if (div_done)
                begin
                    wbase_next = first_reg - IDX_W'(div_rem);
                    wn_next    = n_dec;
                    state_next = B_CHECK;
                end
            end
            B_START:
            begin
                div_start  = 1'b1;
                state_next = B_AVG;
            end
            B_AVG:
            begin
                if (div_done)
                begin
                    avg_next   = sum_reg[SUM_W-1] ? PHASE_W'(-q16) : q16;
                    k_next     = '0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    k_next = k_reg + CNT_W'(1);
                    if ((k_reg + CNT_W'(1)) == cnt_reg)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = after_add_reg ? B_ADD : B_IDLE;
                    end
                end
            end
            B_ADD:
            begin
                // Take the sample into the open window, opening one if needed.
                if (cnt_reg == '0)
                begin
                    first_next = item_reg.sample_index;
                    wbase_next = base_reg;
                    wn_next    = n_dec;
                    sum_next   = SUM_W'($signed(item_reg.angle));
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'($signed(item_reg.angle));
                end
                cnt_next  = cnt_inc;
                close_now = item_reg.chunk_end || (r_reg == n_dec - CNT_W'(1)) ||
                            (cnt_inc >= n_dec);
                if (close_now)
                begin
                    after_add_next = 1'b0;
                    state_next     = B_START;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            sum_reg       <= '0;
            after_add_reg <= 1'b0;
            first_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            sum_reg       <= sum_next;
            after_add_reg <= after_add_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        r_reg     <= r_next;
        wn_reg    <= wn_next;
        base_reg  <= base_next;
        wbase_reg <= wbase_next;
        avg_reg   <= avg_next;
    end

    // Result fields straight from the held window registers.
    assign out_data.phase_value = avg_reg;
    assign out_data.out_index   = cur_index;
    assign out_data.invalid     = (cur_index < IDX_W'(cold));
    assign out_data.last        = ((k_reg + CNT_W'(1)) == cnt_reg);

    `FMPD_ASSERT_IMP(a_emit_in_window, clk, rst_n, out_valid, (cnt_reg != '0) && (k_reg < cnt_reg), "result position outside window")
    `FMPD_ASSERT_NXT(a_last_ends_run, clk, rst_n, out_valid && out_ready && out_data.last, !out_valid, "results continue past window end")
    `FMPD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_MAX, "window count above maximum")
    `FMPD_ASSERT_IMP(a_div_free, clk, rst_n, div_start, !div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

>>> hdl/fm_phase_discriminator_decimator.sv
// FM phase discriminator with boxcar decimation. Each sample transfer takes
// the angle of the sample times the conjugate of the previous one (32768 is
// pi) and the back groups angles into windows aligned to sample_index modulo
// decim_factor, sending every sample of a closed window with the rounded
// window average. For a chunk start or a zero product the front goes from
// the multiply and add states straight to the push; otherwise it runs the
// multiply, the add, 9 to 40 normalizing shifts and 23 CORDIC steps before
// the push, and it takes a new sample only once it has pushed the last one.
// Per sample the back finds the window remainder in its one-bit-per-cycle
// divider, then runs a check and an add step. Each closed window adds a
// division for the average before its results go out, and a change of
// decim_factor while a window is open adds one more division.
// A four-entry queue between them lets each side stall independently; the
// sustained throughput is set by the slower side.
// ----------------------------------------------------------------------------
// fm_phase_discriminator_decimator
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_phase_discriminator_decimator
    import fmpd_pkg::*;
#(
    parameter int MAX_DECIM = MAX_DECIM_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data
);

    logic [DECIM_W-1:0] decim_reg, decim_next;
    logic [COLD_W-1:0]  cold_reg, cold_next;
    logic               push_valid, push_ready, pop_valid, pop_ready;
    phase_item_t        push_data, pop_data;

    // Configuration register writes.
    always_comb
    begin
        decim_next = decim_reg;
        cold_next  = cold_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DECIM: decim_next = cfg_data[DECIM_W-1:0];
                REG_COLD:  cold_next  = cfg_data[COLD_W-1:0];
                default:   decim_next = decim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_reg <= DECIM_RST;
            cold_reg  <= COLD_RST;
        end
        else
        begin
            decim_reg <= decim_next;
            cold_reg  <= cold_next;
        end
    end

    fmpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    fmpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fmpd_back #(
        .MAX_DECIM (MAX_DECIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .decim     (decim_reg),
        .cold      (cold_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
